// ===== rtl/heading_pid_differential_drive_defines.svh =====
// ----------------------------------------------------------------------------
// heading pid differential drive - assertion macros
// shared property forms for the concurrent checks of the controller
// ----------------------------------------------------------------------------
`ifndef HEADING_PID_DIFFERENTIAL_DRIVE_DEFINES_SVH
`define HEADING_PID_DIFFERENTIAL_DRIVE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define HPDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define HPDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpdd_pkg
// widths, constants, register indexes and sequencer states of the
// heading pid controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpdd_pkg;

    // fixed point set-up
    localparam int INTEGRAL_WIDTH = 40;
    localparam int GAIN_FRAC_BITS = 24;

    // field widths
    localparam int ANGLE_W    = 15;
    localparam int ERR_W      = ANGLE_W + 1;
    localparam int DERR_W     = ERR_W + 1;
    localparam int GAIN_W     = 32;
    localparam int SPEED_W    = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // shared multiplier: gain-wide a operand, b operand wide enough for the
    // derivative error and for one half of the integral magnitude
    localparam int MUL_A_W = GAIN_W;
    localparam int INT_HALF_W = (INTEGRAL_WIDTH + 1) / 2;
    localparam int MUL_B_W = (INT_HALF_W > DERR_W) ? INT_HALF_W : DERR_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // integral term limit and its partial product sum
    localparam int KI_LIMIT_BIT = 60;
    localparam int KSUM_W       = PROD_W + MUL_B_W + 1;
    localparam int PRW          = (PROD_W > KI_LIMIT_BIT + 1) ? PROD_W : KI_LIMIT_BIT + 1;

    // accumulator and output scaling
    localparam int ACC_W        = 64;
    localparam int DRIVE_SHIFT  = GAIN_FRAC_BITS + 6;
    localparam int AMAG_W       = DRIVE_SHIFT + 7;
    localparam int SC_W         = AMAG_W + 7;
    localparam int Q_W          = 13;
    localparam int RMAG_W       = 11;
    localparam int RECIP5_SHIFT = 18;

    localparam logic [ACC_W-1:0]   DRIVE_THR   = ACC_W'(100) << DRIVE_SHIFT;
    localparam logic [6:0]         SCALE_NUM   = 7'd78;
    localparam logic [MUL_A_W-1:0] RECIP5      = MUL_A_W'(52429);
    localparam logic [SPEED_W-1:0] SPEED_LIMIT = SPEED_W'(1560);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_ANGLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KP_GAIN      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_GAIN      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KD_GAIN      = 2'd3;

    // reset values of the gains
    localparam logic [GAIN_W-1:0] KP_RESET = 32'd18454938;
    localparam logic [GAIN_W-1:0] KI_RESET = 32'd1678;
    localparam logic [GAIN_W-1:0] KD_RESET = 32'd260885709;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_INT   = 12'b0000_0000_0010,
        S_KP    = 12'b0000_0000_0100,
        S_KD    = 12'b0000_0000_1000,
        S_KI0   = 12'b0000_0001_0000,
        S_KI1   = 12'b0000_0010_0000,
        S_KISUM = 12'b0000_0100_0000,
        S_ACC   = 12'b0000_1000_0000,
        S_ABS   = 12'b0001_0000_0000,
        S_SCALE = 12'b0010_0000_0000,
        S_DIV   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== rtl/heading_pid_differential_drive.sv =====
// ----------------------------------------------------------------------------
// heading_pid_differential_drive
// positional pid heading controller for a differential-drive platform
// ----------------------------------------------------------------------------
// Each transfer on the input stream is one measured heading in 1/64 degree.
// The error (target minus measured) feeds a saturating 40-bit integral, and
// the drive kp*e + ki*sum + kd*(e - previous e), with gains in unsigned
// 8.24 fixed point, is clamped to +-100 and scaled by 15.6 (truncated toward
// zero) into the right wheel speed; the left wheel gets its negation and
// tuser flags a clamped drive. A one-hot sequencer walks each item through
// a single shared 32 x 20 multiplier (proportional, derivative, two halves
// of the integral term, then the divide by five of the output scaling),
// with the three terms summed in one accumulator. The result is held in
// an output register; a finished result that is still waiting stalls the
// sequencer in its last step, so the input is only taken again once that
// register is free. Configuration is written through cfg_we / cfg_addr /
// cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. target_angle takes the low 15 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heading_pid_differential_drive_defines.svh"

module heading_pid_differential_drive (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [hpdd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [hpdd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hpdd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [14:0] measured_angle
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hpdd_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [11:0] left_speed,
                                                            // [23:12] right_speed
    output logic                             m_axis_tuser   // [0] drive_clamped
);

    import hpdd_pkg::*;

    localparam logic [INTEGRAL_WIDTH-1:0] INTEG_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic [INTEGRAL_WIDTH-1:0] INTEG_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

    // sequencer and handshake
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // configuration
    logic [ANGLE_W-1:0] target_reg, target_next;
    logic [GAIN_W-1:0]  kp_reg, kp_next;
    logic [GAIN_W-1:0]  ki_reg, ki_next;
    logic [GAIN_W-1:0]  kd_reg, kd_next;

    // controller state
    logic [ERR_W-1:0]          prev_err_reg, prev_err_next;
    logic [INTEGRAL_WIDTH-1:0] integ_reg, integ_next;

    // working registers of one item
    logic [ERR_W-1:0]       err_reg, err_next;
    logic [ERR_W-1:0]       err_mag_reg, err_mag_next;
    logic                   err_neg_reg, err_neg_next;
    logic [DERR_W-1:0]      derr_mag_reg, derr_mag_next;
    logic                   derr_neg_reg, derr_neg_next;
    logic [2*MUL_B_W-1:0]   int_mag_reg, int_mag_next;
    logic                   int_neg_reg, int_neg_next;
    logic [PRW-1:0]         prod_reg, prod_next;
    logic                   pneg_reg, pneg_next;
    logic [PROD_W-1:0]      kilo_reg, kilo_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [ACC_W-1:0]       amag_reg, amag_next;
    logic                   dneg_reg, dneg_next;
    logic                   clamp_reg, clamp_next;
    logic [Q_W-1:0]         q_reg, q_next;

    // result register
    logic [SPEED_W-1:0] left_reg, left_next;
    logic [SPEED_W-1:0] right_reg, right_next;
    logic               flag_reg, flag_next;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;

    // datapath helpers
    logic [INTEGRAL_WIDTH:0] integ_sum;
    logic [DERR_W-1:0]       derr;
    logic [ACC_W-1:0]        acc_term;
    logic [KSUM_W-1:0]       ki_sum;
    logic [SC_W-1:0]         scaled;
    logic [RMAG_W-1:0]       rmag;
    logic [SPEED_W-1:0]      speed;
    logic                    out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {right_reg, left_reg};
    assign m_axis_tuser  = flag_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_KP:
            begin
                mul_a = kp_reg;
                mul_b = MUL_B_W'(err_mag_reg);
            end
            S_KD:
            begin
                mul_a = kd_reg;
                mul_b = MUL_B_W'(derr_mag_reg);
            end
            S_KI0:
            begin
                mul_a = ki_reg;
                mul_b = int_mag_reg[MUL_B_W-1:0];
            end
            S_KI1:
            begin
                mul_a = ki_reg;
                mul_b = int_mag_reg[2*MUL_B_W-1:MUL_B_W];
            end
            S_DIV:
            begin
                mul_a = RECIP5;
                mul_b = MUL_B_W'(q_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // signed add of the last product into the accumulator
    assign acc_term = ACC_W'(prod_reg);

    // saturating integral update
    assign integ_sum = {integ_reg[INTEGRAL_WIDTH-1], integ_reg}
                     + {{(INTEGRAL_WIDTH+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign derr = {err_reg[ERR_W-1], err_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};

    // integral term from its two partial products
    assign ki_sum = KSUM_W'(kilo_reg) + (KSUM_W'(prod_reg[PROD_W-1:0]) << MUL_B_W);

    // drive magnitude times 78, then drop the fraction and degree bits
    assign scaled = SC_W'(amag_reg[AMAG_W-1:0]) * SC_W'(SCALE_NUM);

    // divide by five through the reciprocal product
    assign rmag  = prod_reg[RECIP5_SHIFT+RMAG_W-1:RECIP5_SHIFT];
    assign speed = clamp_reg ? SPEED_LIMIT : {1'b0, rmag};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        target_next    = target_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        kd_next        = kd_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        err_next       = err_reg;
        err_mag_next   = err_mag_reg;
        err_neg_next   = err_neg_reg;
        derr_mag_next  = derr_mag_reg;
        derr_neg_next  = derr_neg_reg;
        int_mag_next   = int_mag_reg;
        int_neg_next   = int_neg_reg;
        prod_next      = prod_reg;
        pneg_next      = pneg_reg;
        kilo_next      = kilo_reg;
        acc_next       = acc_reg;
        amag_next      = amag_reg;
        dneg_next      = dneg_reg;
        clamp_next     = clamp_reg;
        q_next         = q_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        flag_next      = flag_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes, unknown indexes fall through
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TARGET_ANGLE: target_next = cfg_wdata[ANGLE_W-1:0];
                REG_KP_GAIN:      kp_next     = cfg_wdata[GAIN_W-1:0];
                REG_KI_GAIN:      ki_next     = cfg_wdata[GAIN_W-1:0];
                REG_KD_GAIN:      kd_next     = cfg_wdata[GAIN_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    // error of the new sample
                    err_next   = {target_reg[ANGLE_W-1], target_reg}
                               - {s_axis_tdata[ANGLE_W-1], s_axis_tdata[ANGLE_W-1:0]};
                    state_next = S_INT;
                end
            end
            S_INT:
            begin
                if (integ_sum[INTEGRAL_WIDTH] != integ_sum[INTEGRAL_WIDTH-1])
                begin
                    integ_next = integ_sum[INTEGRAL_WIDTH] ? INTEG_MIN : INTEG_MAX;
                end
                else
                begin
                    integ_next = integ_sum[INTEGRAL_WIDTH-1:0];
                end
                prev_err_next = err_reg;
                err_neg_next  = err_reg[ERR_W-1];
                err_mag_next  = err_reg[ERR_W-1] ? (ERR_W'(0) - err_reg) : err_reg;
                derr_neg_next = derr[DERR_W-1];
                derr_mag_next = derr[DERR_W-1] ? (DERR_W'(0) - derr) : derr;
                state_next    = S_KP;
            end
            S_KP:
            begin
                int_neg_next = integ_reg[INTEGRAL_WIDTH-1];
                int_mag_next = (2*MUL_B_W)'(integ_reg[INTEGRAL_WIDTH-1]
                             ? (INTEGRAL_WIDTH'(0) - integ_reg) : integ_reg);
                acc_next     = '0;
                prod_next    = PRW'(mul_p);
                pneg_next    = err_neg_reg;
                state_next   = S_KD;
            end
            S_KD:
            begin
                acc_next   = pneg_reg ? (acc_reg - acc_term) : (acc_reg + acc_term);
                prod_next  = PRW'(mul_p);
                pneg_next  = derr_neg_reg;
                state_next = S_KI0;
            end
            S_KI0:
            begin
                acc_next   = pneg_reg ? (acc_reg - acc_term) : (acc_reg + acc_term);
                prod_next  = PRW'(mul_p);
                pneg_next  = int_neg_reg;
                state_next = S_KI1;
            end
            S_KI1:
            begin
                kilo_next  = prod_reg[PROD_W-1:0];
                prod_next  = PRW'(mul_p);
                state_next = S_KISUM;
            end
            S_KISUM:
            begin
                // integral term saturates at its magnitude limit
                if (|ki_sum[KSUM_W-1:KI_LIMIT_BIT])
                begin
                    prod_next = PRW'(1) << KI_LIMIT_BIT;
                end
                else
                begin
                    prod_next = PRW'(ki_sum[KI_LIMIT_BIT-1:0]);
                end
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next   = pneg_reg ? (acc_reg - acc_term) : (acc_reg + acc_term);
                state_next = S_ABS;
            end
            S_ABS:
            begin
                dneg_next  = acc_reg[ACC_W-1];
                amag_next  = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                clamp_next = (amag_reg >= DRIVE_THR);
                q_next     = scaled[DRIVE_SHIFT+Q_W-1:DRIVE_SHIFT];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                prod_next  = PRW'(mul_p);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait here while the previous result is still unread
                if (out_free)
                begin
                    right_next     = dneg_reg ? (SPEED_W'(0) - speed) : speed;
                    left_next      = dneg_reg ? speed : (SPEED_W'(0) - speed);
                    flag_next      = clamp_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            kp_reg        <= KP_RESET;
            ki_reg        <= KI_RESET;
            kd_reg        <= KD_RESET;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        err_mag_reg  <= err_mag_next;
        err_neg_reg  <= err_neg_next;
        derr_mag_reg <= derr_mag_next;
        derr_neg_reg <= derr_neg_next;
        int_mag_reg  <= int_mag_next;
        int_neg_reg  <= int_neg_next;
        prod_reg     <= prod_next;
        pneg_reg     <= pneg_next;
        kilo_reg     <= kilo_next;
        acc_reg      <= acc_next;
        amag_reg     <= amag_next;
        dneg_reg     <= dneg_next;
        clamp_reg    <= clamp_next;
        q_reg        <= q_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        flag_reg     <= flag_next;
    end

    // checks
    `HPDD_ASSERT_NOW(a_mirror, out_valid_reg, (SPEED_W'(left_reg + right_reg) == SPEED_W'(0)), "left speed is not the negated right speed")
    `HPDD_ASSERT_NOW(a_clamp_full, out_valid_reg && flag_reg, (right_reg == SPEED_LIMIT) || (right_reg == (SPEED_W'(0) - SPEED_LIMIT)), "clamped drive without full speed")
    `HPDD_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again while an item is in work")
    `HPDD_ASSERT_NEXT(a_result, (state_reg == S_OUT) && out_free, out_valid_reg && s_axis_tready, "finished item not delivered to the output register")

endmodule
